// ===== rtl/xnb_pkg.sv =====
// ----------------------------------------------------------------------------
// xnb_pkg
// types, codes and the condition function shared by the near branch unit
// ----------------------------------------------------------------------------
package xnb_pkg;

	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// register byte addresses
	localparam logic [APB_AW-1:0] ADDR_CODE_LIMIT = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_STACK_32   = 3'd4;

	localparam logic [31:0] CODE_LIMIT_RST = 32'h0000_FFFF;
	localparam logic        STACK_32_RST   = 1'b0;

	typedef enum logic [2:0] {
		OP_JCC     = 3'd0,
		OP_JMP_REL = 3'd1,
		OP_JMP_IND = 3'd2,
		OP_JECXZ   = 3'd3,
		OP_LOOP    = 3'd4,
		OP_LOOPE   = 3'd5,
		OP_LOOPNE  = 3'd6,
		OP_RET     = 3'd7
	} op_t;

	// condition pair, low bit of the code negates
	typedef enum logic [2:0] {
		CC_O  = 3'd0,
		CC_B  = 3'd1,
		CC_Z  = 3'd2,
		CC_BE = 3'd3,
		CC_S  = 3'd4,
		CC_P  = 3'd5,
		CC_L  = 3'd6,
		CC_LE = 3'd7
	} cc_t;

	localparam int unsigned FL_CF = 0;
	localparam int unsigned FL_ZF = 1;
	localparam int unsigned FL_SF = 2;
	localparam int unsigned FL_OF = 3;
	localparam int unsigned FL_PF = 4;

	typedef struct packed {
		op_t                opcode;
		logic [3:0]         cond;
		logic [4:0]         flags;
		logic [31:0]        next_ip;
		logic signed [31:0] displacement;
		logic [31:0]        target_value;
		logic [31:0]        count_value;
		logic               addr32;
		logic [31:0]        stack_ptr;
		logic [15:0]        pop_adjust;
	} req_item_t;

	typedef struct packed {
		logic [31:0] new_ip;
		logic        taken;
		logic        fault;
		logic [31:0] new_count;
		logic [31:0] new_stack_ptr;
	} rsp_item_t;

	typedef struct packed {
		logic [31:0] code_limit;
		logic        stack_is_32bit;
	} cfg_t;

	function automatic logic cond_holds(input logic [3:0] cond, input logic [4:0] fl);
		logic base;
		base = 1'b0;
		case (cc_t'(cond[3:1]))
			CC_O:    base = fl[FL_OF];
			CC_B:    base = fl[FL_CF];
			CC_Z:    base = fl[FL_ZF];
			CC_BE:   base = fl[FL_CF] | fl[FL_ZF];
			CC_S:    base = fl[FL_SF];
			CC_P:    base = fl[FL_PF];
			CC_L:    base = fl[FL_SF] ^ fl[FL_OF];
			CC_LE:   base = fl[FL_ZF] | (fl[FL_SF] ^ fl[FL_OF]);
			default: base = 1'b0;
		endcase
		return cond[0] ? ~base : base;
	endfunction

endpackage

// ===== rtl/xnb_if.sv =====
// ----------------------------------------------------------------------------
// xnb channel interfaces
// valid/ready channels for branch requests and resolved results
// ----------------------------------------------------------------------------
interface xnb_req_if;
	import xnb_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface xnb_rsp_if;
	import xnb_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/xnb_cfg.sv =====
// ----------------------------------------------------------------------------
// xnb_cfg
// APB register block: code segment limit and stack size
// ----------------------------------------------------------------------------
module xnb_cfg
	import xnb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [31:0] code_limit_q;
	logic        stack_32_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_limit_q <= CODE_LIMIT_RST;
			stack_32_q   <= STACK_32_RST;
		end else if (wr_en) begin
			unique case (paddr)
				ADDR_CODE_LIMIT: code_limit_q <= pwdata;
				ADDR_STACK_32:   stack_32_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_CODE_LIMIT: prdata = code_limit_q;
			ADDR_STACK_32:   prdata = {{(APB_DW-1){1'b0}}, stack_32_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.code_limit     = code_limit_q;
	assign cfg.stack_is_32bit = stack_32_q;

endmodule

// ===== rtl/xnb_core.sv =====
// ----------------------------------------------------------------------------
// xnb_core
// input register, branch resolution logic and result register
// ----------------------------------------------------------------------------
module xnb_core
	import xnb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	xnb_req_if.sink   req,
	xnb_rsp_if.source rsp
);

	logic      v_s1;
	req_item_t item_s1;
	logic      v_s2;
	rsp_item_t res_s2;
	logic      adv_s2;
	logic      adv_s1;

	// resolution signals
	logic [31:0] rel_target;
	logic [31:0] target;
	logic [31:0] cnt_dec;
	logic        cnt_nz;
	logic [31:0] sp_adj;
	logic        go;
	logic        fault_c;
	logic        is_loop;
	rsp_item_t   res_c;

	assign adv_s2    = ~v_s2 | rsp.ready;
	assign adv_s1    = ~v_s1 | adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			item_s1 <= req.item;
		end
	end

	always_comb begin
		rel_target = item_s1.next_ip + item_s1.displacement;
		if (item_s1.addr32) begin
			cnt_dec = item_s1.count_value - 32'd1;
			cnt_nz  = |cnt_dec;
		end else begin
			cnt_dec = {item_s1.count_value[31:16], item_s1.count_value[15:0] - 16'd1};
			cnt_nz  = |cnt_dec[15:0];
		end
		if (cfg.stack_is_32bit) begin
			sp_adj = item_s1.stack_ptr + {16'd0, item_s1.pop_adjust};
		end else begin
			sp_adj = {item_s1.stack_ptr[31:16], item_s1.stack_ptr[15:0] + item_s1.pop_adjust};
		end
		is_loop = 1'b0;
		target  = rel_target;
		go      = 1'b0;
		case (item_s1.opcode)
			OP_JCC:     go = cond_holds(item_s1.cond, item_s1.flags);
			OP_JMP_REL: go = 1'b1;
			OP_JMP_IND: begin
				go     = 1'b1;
				target = item_s1.target_value;
			end
			OP_JECXZ: begin
				go = item_s1.addr32 ? (item_s1.count_value == 32'd0)
				                    : (item_s1.count_value[15:0] == 16'd0);
			end
			OP_LOOP: begin
				is_loop = 1'b1;
				go      = cnt_nz;
			end
			OP_LOOPE: begin
				is_loop = 1'b1;
				go      = cnt_nz & item_s1.flags[FL_ZF];
			end
			OP_LOOPNE: begin
				is_loop = 1'b1;
				go      = cnt_nz & ~item_s1.flags[FL_ZF];
			end
			default: begin
				go     = 1'b1;
				target = item_s1.target_value;
			end
		endcase
		// limit check only for a transfer that would happen
		fault_c = go & (target > cfg.code_limit);

		res_c.taken         = go & ~fault_c;
		res_c.fault         = fault_c;
		res_c.new_ip        = res_c.taken ? target : item_s1.next_ip;
		res_c.new_count     = (is_loop && !fault_c) ? cnt_dec : item_s1.count_value;
		res_c.new_stack_ptr = (item_s1.opcode == OP_RET && !fault_c) ? sp_adj
		                                                             : item_s1.stack_ptr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_c;
		end
	end

	assign rsp.valid = v_s2;
	assign rsp.item  = res_s2;

	a_fault_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.fault |-> !res_s2.taken)
		else $error("faulted result marked taken");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted request lost before stage 1");

	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> v_s2)
		else $error("stage 1 item not passed to result register");

	a_count_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !is_loop |-> res_c.new_count == item_s1.count_value)
		else $error("count changed by a non-loop operation");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rsp.ready |=> v_s2 && $stable(res_s2))
		else $error("stalled result dropped or changed");

endmodule

// ===== rtl/x86_near_branch_resolve.sv =====
// ----------------------------------------------------------------------------
// x86_near_branch_resolve
// resolves one 32-bit x86 near branch per item: Jcc, JMP, JECXZ, LOOPx, RET
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req      | in        | valid/ready           | req_item_t (opcode .. pop_adjust)
//  rsp      | out       | valid/ready           | rsp_item_t (new_ip .. new_stack_ptr)
//  apb      | in        | psel/penable, pready  | code_limit @0x0, stack_is_32bit @0x4
//
// result valid once the request has passed the input register, then one pass
// of adds and the limit compare into the result register
// one item per cycle while rsp is ready; the result register frees as it is taken
// arst_n clears both stage valids and loads the register reset values
// a stall on rsp backs up through stage 1 to req.ready
// ----------------------------------------------------------------------------
module x86_near_branch_resolve
	import xnb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	xnb_req_if.sink           req,
	xnb_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	xnb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	xnb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
